FILE: rtl/hds_pkg.sv
// Shared types, constants and helpers for the heat diffusion stencil block.
package hds_pkg;

  localparam int MAX_EDGE = 64;
  localparam int IDX_W    = $clog2(MAX_EDGE);
  localparam int N_W      = IDX_W + 1;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int CELLS    = MAX_EDGE * MAX_EDGE;

  localparam int CMD_W     = 2;
  localparam int CX_W      = 6;
  localparam int VAL_W     = 32;
  localparam int EDGE_W    = 7;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam int FRAC_W = 16;
  localparam int LAP_W  = VAL_W + 2;
  localparam int PROD_W = COEF_W + 1 + LAP_W;
  localparam int ACC_W  = VAL_W + 5;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_CELLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y     = 2'd2;

  localparam logic [EDGE_W-1:0] EDGE_RESET = 7'd64;
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd8192;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [CX_W-1:0]         cell_x;
    logic [CX_W-1:0]         cell_y;
    logic signed [VAL_W-1:0] cell_value;
  } hds_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    step_done;
  } hds_rsp_t;

  // Five-point neighborhood of one cell.
  typedef struct packed {
    logic signed [VAL_W-1:0] c;
    logic signed [VAL_W-1:0] e;
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] n;
    logic signed [VAL_W-1:0] s;
  } hds_nbr_t;

  typedef struct packed {
    logic lap;      // form both Laplacian terms, load accumulator with centre
    logic mul;      // one coefficient product into the product register
    logic mul_y;    // product uses coef_y / y term
    logic acc_add;  // add floored product to accumulator
  } hds_alu_ctl_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] y,
                                                  input logic [IDX_W-1:0] x);
    return {y, x};
  endfunction

endpackage

FILE: rtl/hds_grid_ram.sv
// Grid store: one write port, two registered read ports.
module hds_grid_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [hds_pkg::ADDR_W-1:0]    waddr,
  input  logic [hds_pkg::VAL_W-1:0]     wdata,
  input  logic                          re,
  input  logic [hds_pkg::ADDR_W-1:0]    raddr0,
  input  logic [hds_pkg::ADDR_W-1:0]    raddr1,
  output logic [hds_pkg::VAL_W-1:0]     rdata0,
  output logic [hds_pkg::VAL_W-1:0]     rdata1
);

  logic [hds_pkg::VAL_W-1:0] mem [hds_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: rtl/hds_stencil_alu.sv
// Shared stencil arithmetic: Laplacian terms, one multiplier, accumulate, saturate.
module hds_stencil_alu (
  input  logic                                clk,
  input  hds_pkg::hds_alu_ctl_t               ctl,
  input  hds_pkg::hds_nbr_t                   nbr,
  input  logic [hds_pkg::COEF_W-1:0]          coef_x,
  input  logic [hds_pkg::COEF_W-1:0]          coef_y,
  output logic signed [hds_pkg::VAL_W-1:0]    result
);

  localparam int VAL_W  = hds_pkg::VAL_W;
  localparam int LAP_W  = hds_pkg::LAP_W;
  localparam int PROD_W = hds_pkg::PROD_W;
  localparam int ACC_W  = hds_pkg::ACC_W;
  localparam int FRAC_W = hds_pkg::FRAC_W;
  localparam int TERM_W = PROD_W - FRAC_W;

  logic signed [LAP_W-1:0]  lx;
  logic signed [LAP_W-1:0]  ly;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [LAP_W-1:0]  c2;
  logic signed [LAP_W-1:0]  lx_next;
  logic signed [LAP_W-1:0]  ly_next;
  logic signed [hds_pkg::COEF_W:0] coef_s;
  logic signed [LAP_W-1:0]  mul_b;
  logic signed [TERM_W-1:0] term;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  always_comb begin
    c2      = LAP_W'(nbr.c) <<< 1;
    lx_next = LAP_W'(nbr.e) + LAP_W'(nbr.w) - c2;
    ly_next = LAP_W'(nbr.n) + LAP_W'(nbr.s) - c2;
    coef_s  = ctl.mul_y ? $signed({1'b0, coef_y}) : $signed({1'b0, coef_x});
    mul_b   = ctl.mul_y ? ly : lx;
    // arithmetic shift drops the fraction: floor toward minus infinity
    term    = prod[PROD_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.lap) begin
      lx  <= lx_next;
      ly  <= ly_next;
      acc <= ACC_W'(nbr.c);
    end else if (ctl.acc_add) begin
      acc <= acc + ACC_W'(term);
    end
    if (ctl.mul) begin
      prod <= PROD_W'(coef_s * mul_b);
    end
  end

  always_comb begin
    if (acc > SAT_MAX) begin
      result = SAT_MAX[VAL_W-1:0];
    end else if (acc < SAT_MIN) begin
      result = SAT_MIN[VAL_W-1:0];
    end else begin
      result = acc[VAL_W-1:0];
    end
  end

endmodule

FILE: rtl/heat_diffusion_stencil_step_top.sv
// Top level: command sequencer, ping-pong grid stores and stencil arithmetic.
// Holds a periodic square grid of Q16.16 cells in two stores that swap roles on
// every step. Write and read commands first wrap cell_x and cell_y into the grid
// edge by an iterative compare-subtract, one quotient bit a cycle, then make one
// store access. A step command walks an n by n grid cell by cell: each cell's
// neighbors are read on the two store read ports in states S_RD0, S_RD1 and
// S_RD2, then one shared multiplier forms the x and y products in turn before
// the new value is written to the other store. Unused commands go straight to
// the result with no store access. Only one command is in flight; a finished
// result sits in the output register while the next command is taken. Cells
// must be written before they are read or stepped over.
module heat_diffusion_stencil_step_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  hds_pkg::hds_req_t                  req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output hds_pkg::hds_rsp_t                  rsp,
  input  logic                               cfg_wen,
  input  logic [hds_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [hds_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int IDX_W  = hds_pkg::IDX_W;
  localparam int N_W    = hds_pkg::N_W;
  localparam int CX_W   = hds_pkg::CX_W;
  localparam int VAL_W  = hds_pkg::VAL_W;
  localparam int EDGE_W = hds_pkg::EDGE_W;
  localparam int ADDR_W = hds_pkg::ADDR_W;
  localparam int K_W    = $clog2(CX_W);
  localparam int D_W    = N_W + CX_W;
  localparam int CMP_W  = (EDGE_W > N_W) ? EDGE_W : N_W;
  localparam int CMD_W_L = hds_pkg::CMD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_ACCESS, S_RD0, S_RD1, S_RD2, S_CAP, S_LAP,
    S_MULX, S_MULY, S_ACC, S_WR, S_FINISH
  } state_t;

  state_t state;

  logic [EDGE_W-1:0]            edge_cells;
  logic [hds_pkg::COEF_W-1:0]   coef_x;
  logic [hds_pkg::COEF_W-1:0]   coef_y;
  logic                         cur_b;

  logic [CMD_W_L-1:0]           cmd_q;
  logic [CX_W-1:0]              xr;
  logic [CX_W-1:0]              yr;
  logic [VAL_W-1:0]             value_q;
  logic [K_W-1:0]               bit_k;
  logic [IDX_W-1:0]             sx;
  logic [IDX_W-1:0]             sy;
  hds_pkg::hds_nbr_t            nbr;

  logic [N_W-1:0]    edge_use;
  logic [D_W-1:0]    div_sh;
  logic              x_ge;
  logic              y_ge;
  logic [N_W-1:0]    sx_inc;
  logic [N_W-1:0]    sy_inc;
  logic [IDX_W-1:0]  xe;
  logic [IDX_W-1:0]  xw;
  logic [IDX_W-1:0]  yn;
  logic [IDX_W-1:0]  ys;
  logic              row_end;
  logic              col_end;

  logic              ram_re;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;
  logic              we_a;
  logic              we_b;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  qa0;
  logic [VAL_W-1:0]  qa1;
  logic [VAL_W-1:0]  qb0;
  logic [VAL_W-1:0]  qb1;
  logic [VAL_W-1:0]  src_q0;
  logic [VAL_W-1:0]  src_q1;

  hds_pkg::hds_alu_ctl_t       alu_ctl;
  logic signed [VAL_W-1:0]     alu_result;

  // Grid edge in use, clamped to 2..MAX_EDGE.
  always_comb begin
    if (edge_cells < EDGE_W'(2)) begin
      edge_use = N_W'(2);
    end else if (CMP_W'(edge_cells) > CMP_W'(hds_pkg::MAX_EDGE)) begin
      edge_use = N_W'(hds_pkg::MAX_EDGE);
    end else begin
      edge_use = N_W'(edge_cells);
    end
  end

  // Compare-subtract step of the index wrap, shared by both coordinates.
  always_comb begin
    div_sh = D_W'(edge_use) << bit_k;
    x_ge   = D_W'(xr) >= div_sh;
    y_ge   = D_W'(yr) >= div_sh;
  end

  // Wrap-around neighbors of the current stencil cell.
  always_comb begin
    sx_inc  = N_W'(sx) + N_W'(1);
    sy_inc  = N_W'(sy) + N_W'(1);
    col_end = sx_inc == edge_use;
    row_end = sy_inc == edge_use;
    xe      = col_end ? '0 : sx_inc[IDX_W-1:0];
    yn      = row_end ? '0 : sy_inc[IDX_W-1:0];
    xw      = (sx == '0) ? IDX_W'(edge_use - N_W'(1)) : sx - IDX_W'(1);
    ys      = (sy == '0) ? IDX_W'(edge_use - N_W'(1)) : sy - IDX_W'(1);
  end

  assign src_q0 = cur_b ? qb0 : qa0;
  assign src_q1 = cur_b ? qb1 : qa1;

  // Store access control.
  always_comb begin
    ram_re = 1'b0;
    raddr0 = hds_pkg::cell_addr(sy, sx);
    raddr1 = hds_pkg::cell_addr(sy, xe);
    we_a   = 1'b0;
    we_b   = 1'b0;
    waddr  = hds_pkg::cell_addr(sy, sx);
    wdata  = alu_result;
    unique case (state)
      S_ACCESS: begin
        raddr0 = hds_pkg::cell_addr(yr[IDX_W-1:0], xr[IDX_W-1:0]);
        waddr  = hds_pkg::cell_addr(yr[IDX_W-1:0], xr[IDX_W-1:0]);
        wdata  = value_q;
        if (cmd_q == hds_pkg::CMD_WRITE) begin
          we_a = !cur_b;
          we_b = cur_b;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_RD0: begin
        ram_re = 1'b1;
      end
      S_RD1: begin
        ram_re = 1'b1;
        raddr0 = hds_pkg::cell_addr(sy, xw);
        raddr1 = hds_pkg::cell_addr(yn, sx);
      end
      S_RD2: begin
        ram_re = 1'b1;
        raddr0 = hds_pkg::cell_addr(ys, sx);
        raddr1 = hds_pkg::cell_addr(ys, sx);
      end
      S_WR: begin
        // new grid goes to the store that is not current
        we_a = cur_b;
        we_b = !cur_b;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alu_ctl         = '0;
    alu_ctl.lap     = state == S_LAP;
    alu_ctl.mul     = (state == S_MULX) || (state == S_MULY);
    alu_ctl.mul_y   = state == S_MULY;
    alu_ctl.acc_add = (state == S_MULY) || (state == S_ACC);
  end

  assign req_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_b      <= 1'b0;
      rsp_valid  <= 1'b0;
      edge_cells <= hds_pkg::EDGE_RESET;
      coef_x     <= hds_pkg::COEF_RESET;
      coef_y     <= hds_pkg::COEF_RESET;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_addr)
          hds_pkg::CFG_EDGE_CELLS: edge_cells <= cfg_wdata[EDGE_W-1:0];
          hds_pkg::CFG_COEF_X:     coef_x     <= cfg_wdata;
          hds_pkg::CFG_COEF_Y:     coef_y     <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // in S_FINISH the output register is refilled instead
      if (rsp_valid && rsp_ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q   <= req.cmd;
            xr      <= req.cell_x;
            yr      <= req.cell_y;
            value_q <= req.cell_value;
            bit_k   <= K_W'(CX_W - 1);
            sx      <= '0;
            sy      <= '0;
            unique case (req.cmd)
              hds_pkg::CMD_WRITE, hds_pkg::CMD_READ: state <= S_MOD;
              hds_pkg::CMD_STEP:                     state <= S_RD0;
              default:                               state <= S_FINISH;
            endcase
          end
        end
        S_MOD: begin
          if (x_ge) begin
            xr <= xr - div_sh[CX_W-1:0];
          end
          if (y_ge) begin
            yr <= yr - div_sh[CX_W-1:0];
          end
          bit_k <= bit_k - K_W'(1);
          if (bit_k == '0) begin
            state <= S_ACCESS;
          end
        end
        S_ACCESS: state <= S_FINISH;
        S_RD0:    state <= S_RD1;
        S_RD1: begin
          nbr.c <= src_q0;
          nbr.e <= src_q1;
          state <= S_RD2;
        end
        S_RD2: begin
          nbr.w <= src_q0;
          nbr.n <= src_q1;
          state <= S_CAP;
        end
        S_CAP: begin
          nbr.s <= src_q0;
          state <= S_LAP;
        end
        S_LAP:  state <= S_MULX;
        S_MULX: state <= S_MULY;
        S_MULY: state <= S_ACC;
        S_ACC:  state <= S_WR;
        S_WR: begin
          if (col_end) begin
            sx <= '0;
            sy <= yn;
          end else begin
            sx <= xe;
          end
          if (col_end && row_end) begin
            cur_b <= !cur_b;
            state <= S_FINISH;
          end else begin
            state <= S_RD0;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.read_value <= (cmd_q == hds_pkg::CMD_READ) ? src_q0 : '0;
            rsp.step_done  <= cmd_q == hds_pkg::CMD_STEP;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hds_grid_ram u_store_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (ram_re),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (qa0),
    .rdata1 (qa1)
  );

  hds_grid_ram u_store_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (ram_re),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (qb0),
    .rdata1 (qb1)
  );

  hds_stencil_alu u_alu (
    .clk    (clk),
    .ctl    (alu_ctl),
    .nbr    (nbr),
    .coef_x (coef_x),
    .coef_y (coef_y),
    .result (alu_result)
  );

  // Only one store is written in any cycle.
  assert property (@(posedge clk) disable iff (rst) !(we_a && we_b))
    else $error("both grid stores written in one cycle");

  // Wrapped coordinates lie inside the grid when the store is accessed.
  assert property (@(posedge clk) disable iff (rst)
    state == S_ACCESS |-> (N_W'(xr) < edge_use) && (N_W'(yr) < edge_use))
    else $error("wrapped cell index beyond grid edge");

  // Stencil walk stays inside the grid.
  assert property (@(posedge clk) disable iff (rst)
    state == S_RD0 |-> (N_W'(sx) < edge_use) && (N_W'(sy) < edge_use))
    else $error("stencil walk left the grid");

  // The last cell of a step swaps the stores.
  assert property (@(posedge clk) disable iff (rst)
    state == S_WR && col_end && row_end |=> cur_b != $past(cur_b))
    else $error("stores did not swap after step");

  // A step result never carries read data.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.step_done |-> rsp.read_value == '0)
    else $error("step result with nonzero read value");

endmodule
